@@ src/rxlf_pkg.sv @@
// Package for the modem receive line framer: result descriptor type,
// receive mode encoding, control characters and prefix tables.
// No dependencies; all other files of the framer but rxlf_in_reg import it.
`default_nettype none

package rxlf_pkg;

  // Receive modes. Line mode is the reset mode.
  typedef enum logic [2:0] {
    MODE_LINE   = 3'd0,
    MODE_MSG    = 3'd1,
    MODE_TIME   = 3'd2,
    MODE_LEN_HI = 3'd3,
    MODE_LEN_LO = 3'd4,
    MODE_BODY   = 3'd5
  } mode_t;

  // Frame kinds as reported on the result channel.
  localparam logic [1:0] KIND_LINE   = 2'd0;
  localparam logic [1:0] KIND_MSG    = 2'd1;
  localparam logic [1:0] KIND_TIME   = 2'd2;
  localparam logic [1:0] KIND_PACKET = 2'd3;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  // Packet header and trailer bytes beyond the announced length.
  localparam logic [16:0] PKT_OVERHEAD = 17'd14;

  // Number of leading line bytes that take part in prefix tests.
  localparam int unsigned PREFIX_MAX = 8;

  // One result descriptor.
  typedef struct packed {
    logic        write_valid;
    logic [11:0] write_index;
    logic [7:0]  write_byte;
    logic        frame_done;
    logic [1:0]  frame_kind;
    logic [12:0] frame_length;
    logic        overflow;
  } result_t;

  // Packet opening "#H".
  function automatic logic [7:0] hash_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h23;
      3'd1:    c = 8'h48;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Network time prefix "+QNITZ: ".
  function automatic logic [7:0] time_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0: c = 8'h2B;
      3'd1: c = 8'h51;
      3'd2: c = 8'h4E;
      3'd3: c = 8'h49;
      3'd4: c = 8'h54;
      3'd5: c = 8'h5A;
      3'd6: c = 8'h3A;
      3'd7: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Short message prefix "+CMT:".
  function automatic logic [7:0] msg_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h2B;
      3'd1:    c = 8'h43;
      3'd2:    c = 8'h4D;
      3'd3:    c = 8'h54;
      3'd4:    c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/modem_rx_line_framer.sv @@
// Modem receive line framer, top level. A byte accepted is held in the input register,
// then its descriptor enters the result register and shows on the result port.
// Throughput: one byte per cycle, sustained, whenever the result side does not stall.
// Reset (synchronous, rst_n low) empties both register stages and returns the
// framer to line mode with an empty buffer count and packet length zero.
// Depends on rxlf_pkg, rxlf_in_reg, rxlf_parse and rxlf_out_reg.
`default_nettype none

module modem_rx_line_framer #(
  parameter int unsigned BUFFER_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_write_valid,
  output logic [11:0] out_write_index,
  output logic [7:0]  out_write_byte,
  output logic        out_frame_done,
  output logic [1:0]  out_frame_kind,
  output logic [12:0] out_frame_length,
  output logic        out_overflow
);

  import rxlf_pkg::*;

  // The design is a two register pipeline. The input register holds one
  // accepted request; the parser turns it into a descriptor with a single
  // pass of logic and the result register captures it. The framing state
  // (mode, fill count, packet length, prefix flags) lives in the parser and
  // moves on exactly when a descriptor enters the result register, so each
  // request updates the state once, in order.

  logic    advance;
  logic    held_valid;
  logic    step;
  logic [7:0] held_byte;
  result_t parse_result;
  result_t out_result;

  rxlf_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  // The parser steps only when a held byte really moves to the result register.
  assign step = held_valid & advance;

  rxlf_parse #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (held_byte),
    .result  (parse_result)
  );

  rxlf_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_valid  (held_valid),
    .load_result (parse_result),
    .advance     (advance),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_result  (out_result)
  );

  // Unpack the descriptor onto the result ports.
  assign out_write_valid  = out_result.write_valid;
  assign out_write_index  = out_result.write_index;
  assign out_write_byte   = out_result.write_byte;
  assign out_frame_done   = out_result.frame_done;
  assign out_frame_kind   = out_result.frame_kind;
  assign out_frame_length = out_result.frame_length;
  assign out_overflow     = out_result.overflow;

  // A line, message or time frame always carries the write of its zero terminator.
  a_line_term : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done && out_frame_kind != KIND_PACKET) |->
      (out_write_valid && out_write_byte == 8'h00))
    else $error("line frame without terminator write");

  // A dropped byte never writes the buffer.
  a_drop_no_write : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow && !out_frame_done) |-> !out_write_valid)
    else $error("dropped byte produced a write");

  // A finished frame always has a non-zero length.
  a_frame_len : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> (out_frame_length != 13'd0))
    else $error("finished frame with zero length");

  // Requests are refused only while the input register is full.
  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (held_valid && out_valid && out_stall))
    else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

@@ src/rxlf_in_reg.sv @@
// Input register stage of the modem receive line framer.
// Holds one received byte until the parser can take it; no package use.
`default_nettype none

module rxlf_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;

  // The stage only refuses a request when it is full and cannot move on.
  assign in_stall = valid_r & ~advance;

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
      byte_nxt  = in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;

endmodule

`default_nettype wire

@@ src/rxlf_parse.sv @@
// Framing state machine of the modem receive line framer: mode, fill count,
// packet length and prefix match flags, and the descriptor for one byte.
// Depends on rxlf_pkg.
`default_nettype none

module rxlf_parse #(
  parameter int unsigned BUFFER_DEPTH = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output rxlf_pkg::result_t result
);

  import rxlf_pkg::*;

  localparam int unsigned FW = $clog2(BUFFER_DEPTH);
  localparam int unsigned LW = FW + 1;
  localparam logic [FW-1:0] FILL_LAST = FW'(BUFFER_DEPTH - 1);
  localparam logic [LW-1:0] CAP_LAST  = LW'(BUFFER_DEPTH - 1);

  mode_t          mode_r, mode_nxt;
  logic [FW-1:0]  fill_r, fill_nxt;
  logic [15:0]    plen_r, plen_nxt;
  logic           hash_ok_r, hash_ok_nxt;
  logic           time_ok_r, time_ok_nxt;
  logic           msg_ok_r, msg_ok_nxt;

  logic           is_lf, is_cr, full, line_data, in_prefix, first;
  logic [2:0]     pidx;
  logic [LW-1:0]  fill_inc;
  logic           hash_m, time_m, msg_m;
  logic           hash_hit, time_hit, msg_hit;
  logic [15:0]    plen_eff;
  logic           to_body, pkt_done, pkt_cap;

  // Events shared by the next state and output logic.
  always_comb begin
    is_lf     = (rx_byte == CHAR_LF);
    is_cr     = (rx_byte == CHAR_CR);
    full      = (fill_r >= FILL_LAST);
    line_data = ~is_lf & ~is_cr & ~full;
    in_prefix = (fill_r < FW'(PREFIX_MAX));
    first     = (fill_r == '0);
    pidx      = fill_r[2:0];
    fill_inc  = LW'(fill_r) + LW'(1);

    hash_m   = (first | hash_ok_r) & (rx_byte == hash_char(pidx));
    time_m   = (first | time_ok_r) & (rx_byte == time_char(pidx));
    msg_m    = (first | msg_ok_r)  & (rx_byte == msg_char(pidx));
    hash_hit = (fill_r == FW'(1)) & hash_m;
    time_hit = (fill_r == FW'(7)) & time_m;
    msg_hit  = (fill_r == FW'(4)) & msg_m;

    unique case (mode_r)
      MODE_LEN_HI: plen_eff = {rx_byte, 8'h00};
      MODE_LEN_LO: plen_eff = {plen_r[15:8], rx_byte};
      default:     plen_eff = plen_r;
    endcase
    to_body  = (mode_r == MODE_LEN_LO) | (mode_r == MODE_BODY);
    pkt_done = to_body & (17'(fill_inc) >= (17'(plen_eff) + PKT_OVERHEAD));
    pkt_cap  = (fill_inc >= CAP_LAST);
  end

  // Next mode.
  always_comb begin
    mode_nxt = mode_r;
    if (step) begin
      unique case (mode_r)
        MODE_MSG, MODE_TIME: begin
          if (is_lf) mode_nxt = MODE_LINE;
        end
        MODE_LEN_HI: begin
          mode_nxt = pkt_cap ? MODE_LINE : MODE_LEN_LO;
        end
        MODE_LEN_LO, MODE_BODY: begin
          mode_nxt = (pkt_done | pkt_cap) ? MODE_LINE : MODE_BODY;
        end
        default: begin
          if (line_data) begin
            priority if (hash_hit) mode_nxt = MODE_LEN_HI;
            else if (time_hit)     mode_nxt = MODE_TIME;
            else if (msg_hit)      mode_nxt = MODE_MSG;
            else                   mode_nxt = mode_r;
          end
        end
      endcase
    end
  end

  // Fill count, packet length and prefix flags.
  always_comb begin
    fill_nxt    = fill_r;
    plen_nxt    = plen_r;
    hash_ok_nxt = hash_ok_r;
    time_ok_nxt = time_ok_r;
    msg_ok_nxt  = msg_ok_r;
    if (step) begin
      unique case (mode_r)
        MODE_MSG, MODE_TIME: begin
          if (is_lf) fill_nxt = '0;
          else if (line_data) fill_nxt = fill_inc[FW-1:0];
        end
        MODE_LEN_HI, MODE_LEN_LO, MODE_BODY: begin
          plen_nxt = plen_eff;
          fill_nxt = (pkt_done | pkt_cap) ? '0 : fill_inc[FW-1:0];
        end
        default: begin
          if (is_lf) begin
            fill_nxt = '0;
          end else if (line_data) begin
            fill_nxt = (time_hit | msg_hit) ? '0 : fill_inc[FW-1:0];
            if (in_prefix) begin
              hash_ok_nxt = hash_m;
              time_ok_nxt = time_m;
              msg_ok_nxt  = msg_m;
            end
          end
        end
      endcase
    end
  end

  // Descriptor for the current byte.
  always_comb begin
    result = '0;
    unique case (mode_r)
      MODE_MSG, MODE_TIME: begin
        if (is_lf) begin
          result.write_valid  = 1'b1;
          result.write_index  = 12'(fill_r);
          result.frame_done   = 1'b1;
          result.frame_kind   = (mode_r == MODE_MSG) ? KIND_MSG : KIND_TIME;
          result.frame_length = 13'(fill_inc);
        end else if (is_cr) begin
          result = '0;
        end else if (full) begin
          result.overflow = 1'b1;
        end else begin
          result.write_valid = 1'b1;
          result.write_index = 12'(fill_r);
          result.write_byte  = rx_byte;
        end
      end
      MODE_LEN_HI, MODE_LEN_LO, MODE_BODY: begin
        result.write_valid = 1'b1;
        result.write_index = 12'(fill_r);
        result.write_byte  = rx_byte;
        if (pkt_done | pkt_cap) begin
          result.frame_done   = 1'b1;
          result.frame_kind   = KIND_PACKET;
          result.frame_length = 13'(fill_inc + LW'(1));
          result.overflow     = ~pkt_done;
        end
      end
      default: begin
        if (is_lf) begin
          result.write_valid = 1'b1;
          result.write_index = 12'(fill_r);
          if (!first) begin
            result.frame_done   = 1'b1;
            result.frame_kind   = KIND_LINE;
            result.frame_length = 13'(fill_inc);
          end
        end else if (is_cr) begin
          result = '0;
        end else if (full) begin
          result.overflow = 1'b1;
        end else begin
          result.write_valid = 1'b1;
          result.write_index = 12'(fill_r);
          result.write_byte  = rx_byte;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_LINE;
      fill_r    <= '0;
      plen_r    <= '0;
      hash_ok_r <= 1'b0;
      time_ok_r <= 1'b0;
      msg_ok_r  <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      fill_r    <= fill_nxt;
      plen_r    <= plen_nxt;
      hash_ok_r <= hash_ok_nxt;
      time_ok_r <= time_ok_nxt;
      msg_ok_r  <= msg_ok_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/rxlf_out_reg.sv @@
// Result register of the modem receive line framer.
// Holds one descriptor until the receiving side takes it; depends on rxlf_pkg.
`default_nettype none

module rxlf_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_valid,
  input  rxlf_pkg::result_t load_result,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_stall,
  output rxlf_pkg::result_t out_result
);

  import rxlf_pkg::*;

  logic    valid_r, valid_nxt;
  result_t result_r, result_nxt;

  // The register can take a new descriptor when empty or being emptied.
  assign advance = ~valid_r | ~out_stall;

  always_comb begin
    valid_nxt  = valid_r;
    result_nxt = result_r;
    if (advance) begin
      valid_nxt  = load_valid;
      result_nxt = load_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

`default_nettype wire
